// ----- design/fre_pkg.sv -----
// Package for the framed RMS energy block: payload types, register indexes and widths.
package fre_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int RMS_W       = 16;
  localparam int FRAME_MAX_DEFAULT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_LEN   = 1'd1;

  localparam logic [CFG_W-1:0] FRAME_LEN_RESET = 13'd1024;
  localparam logic [CFG_W-1:0] HOP_LEN_RESET   = 13'd512;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } fre_in_t;

  typedef struct packed {
    logic [RMS_W-1:0] rms_value;
    logic             short_frame;
  } fre_out_t;

endpackage

// ----- design/framed_rms_energy.sv -----
// Top level of the framed RMS energy block: sample ring, running sum, divider and root.
//
// The block takes one signed sample per request and keeps the most recent
// frame-length samples in a single-port-write, single-port-read ring memory
// together with a running sum of their squares. A request that completes no
// frame is handled in its accept cycle, which reads the sample leaving the
// window and writes the new one, and in the update cycle after it, which folds
// both into the sum. A request that completes a frame, or a stream-ending
// request before any full frame, additionally runs the mean-square divider
// (one quotient bit per cycle, a SUMW-bit quotient, 43 bits at the default
// depth) and the square-root unit (one result bit per cycle), and then hands
// the result to the output register once that register is free. A finished
// result waits in the output register, and the next request is taken while it
// waits. Writing either configuration register clears the stream state, exactly
// as the end of a stream does. Register values of zero are treated as one, and
// values above FRAME_MAX as FRAME_MAX. The ring needs no clearing after reset,
// since an entry is only read after it has been written in the current stream.
module framed_rms_energy #(
  parameter int FRAME_MAX = fre_pkg::FRAME_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fre_pkg::fre_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fre_pkg::fre_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [fre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fre_pkg::CFG_W-1:0]     cfg_wdata
);
  import fre_pkg::*;

  // Address, length and sum widths follow from the ring depth; the root width follows from the sample width.
  localparam int AW    = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
  localparam int LW    = $clog2(FRAME_MAX + 1);
  localparam int SQW   = 2 * SAMPLE_BITS;
  localparam int SUMW  = 2 * SAMPLE_BITS - 1 + AW;
  localparam int RW    = 2 * SAMPLE_BITS;
  localparam int DCW   = $clog2(SUMW + 1);
  localparam int SCW   = $clog2(RW / 2 + 1);
  localparam logic [LW:0] FRAME_MAX_W = (LW+1)'(FRAME_MAX);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SQRT = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] frame_len_r, frame_len_nxt;
  logic [CFG_W-1:0] hop_len_r, hop_len_nxt;

  // Stream state.
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [LW-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]   phase_r, phase_nxt;
  logic            emitted_r, emitted_nxt;

  // Per-request working registers.
  logic [SQW-1:0]  xsq_r, xsq_nxt;
  logic            last_r, last_nxt;
  logic            short_r, short_nxt;

  // Divider and root unit.
  logic [SUMW-1:0] dq_r, dq_nxt;
  logic [LW-1:0]   rem_r, rem_nxt;
  logic [LW-1:0]   div_r, div_nxt;
  logic [DCW-1:0]  dcnt_r, dcnt_nxt;
  logic [RW-1:0]   sv_r, sv_nxt;
  logic [RW-1:0]   sres_r, sres_nxt;
  logic [RW-1:0]   sbit_r, sbit_nxt;
  logic [SCW-1:0]  scnt_r, scnt_nxt;

  logic            out_valid_r, out_valid_nxt;
  fre_out_t        out_r, out_nxt;

  // Ring memory.
  logic signed [SAMPLE_BITS-1:0] ring [FRAME_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic [AW-1:0]                 rd_addr;

  logic [31:0]     len_ext, hop_ext;
  logic [LW-1:0]   len_w, hop_w;
  logic [LW:0]     old_sum;
  logic            accept;
  logic [SAMPLE_BITS-1:0] in_mag, rd_mag;
  logic [SQW-1:0]  old_sq;
  logic [SUMW-1:0] sum_upd;
  logic [LW-1:0]   fill_upd;
  logic            emit_full;
  logic [LW:0]     dtrial;
  logic            dge;
  logic [RW-1:0]   strial;

  // Register values are clamped to the range the ring supports.
  always_comb begin
    len_ext = 32'(frame_len_r);
    hop_ext = 32'(hop_len_r);
    if (len_ext == 32'd0) begin
      len_ext = 32'd1;
    end else if (len_ext > 32'(FRAME_MAX)) begin
      len_ext = 32'(FRAME_MAX);
    end
    if (hop_ext == 32'd0) begin
      hop_ext = 32'd1;
    end else if (hop_ext > 32'(FRAME_MAX)) begin
      hop_ext = 32'(FRAME_MAX);
    end
    len_w = len_ext[LW-1:0];
    hop_w = hop_ext[LW-1:0];
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // The sample leaving the window sits one frame length behind the write pointer.
  assign old_sum = (LW+1)'(wp_r) + (FRAME_MAX_W - (LW+1)'(len_w));
  assign rd_addr = (old_sum >= FRAME_MAX_W) ? AW'(old_sum - FRAME_MAX_W) : AW'(old_sum);

  assign in_mag = in_data.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_data.sample)
                                                : SAMPLE_BITS'(in_data.sample);
  assign rd_mag = rd_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rd_r) : SAMPLE_BITS'(rd_r);

  // Read-first ring: with a full-depth frame the read and write slots coincide.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r       <= ring[rd_addr];
      ring[wp_r] <= in_data.sample;
    end
  end

  assign old_sq    = (fill_r >= len_w) ? SQW'(rd_mag) * SQW'(rd_mag) : '0;
  assign sum_upd   = sum_r - SUMW'(old_sq) + SUMW'(xsq_r);
  assign fill_upd  = (fill_r < len_w) ? fill_r + 1'b1 : fill_r;
  // A full frame ends either when the window first fills or one hop after the last one.
  assign emit_full = (fill_r < len_w) ? (fill_upd == len_w)
                                      : ((LW'(phase_r) + 1'b1) >= hop_w);

  assign dtrial = {rem_r, dq_r[SUMW-1]};
  assign dge    = dtrial >= {1'b0, div_r};
  assign strial = sres_r + sbit_r;

  always_comb begin
    state_nxt     = state_r;
    frame_len_nxt = frame_len_r;
    hop_len_nxt   = hop_len_r;
    sum_nxt       = sum_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    phase_nxt     = phase_r;
    emitted_nxt   = emitted_r;
    xsq_nxt       = xsq_r;
    last_nxt      = last_r;
    short_nxt     = short_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    dcnt_nxt      = dcnt_r;
    sv_nxt        = sv_r;
    sres_nxt      = sres_r;
    sbit_nxt      = sbit_r;
    scnt_nxt      = scnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          xsq_nxt   = SQW'(in_mag) * SQW'(in_mag);
          last_nxt  = in_data.last;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        sum_nxt   = sum_upd;
        wp_nxt    = (32'(wp_r) == FRAME_MAX - 1) ? '0 : wp_r + 1'b1;
        fill_nxt  = fill_upd;
        phase_nxt = emit_full ? '0 : phase_r + 1'b1;
        dq_nxt    = sum_upd;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = S_IDLE;
        if (emit_full) begin
          emitted_nxt = 1'b1;
          div_nxt     = len_w;
          short_nxt   = 1'b0;
          state_nxt   = S_DIV;
        end else if (last_r && !emitted_r) begin
          // Stream ended before any full frame: report the samples seen so far.
          div_nxt   = fill_upd;
          short_nxt = 1'b1;
          state_nxt = S_DIV;
        end
        if (last_r) begin
          sum_nxt     = '0;
          wp_nxt      = '0;
          fill_nxt    = '0;
          phase_nxt   = '0;
          emitted_nxt = 1'b0;
        end
      end
      S_DIV: begin
        rem_nxt  = dge ? LW'(dtrial - {1'b0, div_r}) : dtrial[LW-1:0];
        dq_nxt   = {dq_r[SUMW-2:0], dge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (32'(dcnt_r) == SUMW - 1) begin
          sv_nxt    = dq_nxt[RW-1:0];
          sres_nxt  = '0;
          sbit_nxt  = RW'(1) << (RW - 2);
          scnt_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sv_r >= strial) begin
          sv_nxt   = sv_r - strial;
          sres_nxt = (sres_r >> 1) + sbit_r;
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        scnt_nxt = scnt_r + 1'b1;
        if (32'(scnt_r) == RW / 2 - 1) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_nxt.rms_value   = sres_r[RMS_W-1:0];
          out_nxt.short_frame = short_r;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // The user must write only while idle; the block does not enforce it. Each write restarts the stream.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_LEN: frame_len_nxt = cfg_wdata;
        REG_HOP_LEN:   hop_len_nxt   = cfg_wdata;
        default:       ;
      endcase
      sum_nxt     = '0;
      wp_nxt      = '0;
      fill_nxt    = '0;
      phase_nxt   = '0;
      emitted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_len_r <= FRAME_LEN_RESET;
      hop_len_r   <= HOP_LEN_RESET;
      sum_r       <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      phase_r     <= '0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_len_r <= frame_len_nxt;
      hop_len_r   <= hop_len_nxt;
      sum_r       <= sum_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      phase_r     <= phase_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xsq_r  <= xsq_nxt;
    last_r <= last_nxt;
    short_r <= short_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    dcnt_r <= dcnt_nxt;
    sv_r   <= sv_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
    scnt_r <= scnt_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_UPD)
    else $error("accepted request did not reach the update cycle");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_w)
    else $error("fill count exceeds frame length");

  a_phase_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(phase_r) < hop_w || fill_r < len_w)
    else $error("hop phase reached hop length");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD |-> sres_r <= (RW'(1) << (SAMPLE_BITS - 1)))
    else $error("square root exceeds full scale");

endmodule
